@@ rtl/twcr_pkg.sv @@
// ---------------------------------------------------------------------------
// Textured wall column renderer package
// Shared command codes, face codes and the front-to-back queue entry type.
// ---------------------------------------------------------------------------
`default_nettype none
package twcr_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_WEST  = 2'd2;
    localparam logic [1:0] FACE_EAST  = 2'd3;

    localparam logic [2:0] REG_WIDTH_NORTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT_NORTH = 3'd4;

    // Wall tile edge in world units; the offset math relies on a power of two.
    localparam int TILE_SIZE = 64;

    // One classified item handed from the front part to the back part.
    typedef struct packed {
        t_cmd         cmd;
        logic [1:0]   face;
        logic [13:0]  addr;
        logic [31:0]  texel;
        logic [11:0]  column_x;
        logic [5:0]   tex_col;
        logic [6:0]   height;
        logic signed [16:0] top;
        logic signed [16:0] end_row;
        logic [15:0]  line_length;
    } t_item;

endpackage
`default_nettype wire

@@ rtl/twcr_front.sv @@
// ---------------------------------------------------------------------------
// Front part
// Accepts input beats, picks the face and texel column of begin beats and
// pushes classified items into a two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none
module twcr_front #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [1:0]   i_cmd,
    input  wire logic [1:0]   i_face,
    input  wire logic [5:0]   i_tex_row,
    input  wire logic [5:0]   i_tex_col,
    input  wire logic [31:0]  i_texel,
    input  wire logic [11:0]  i_column_x,
    input  wire logic         i_hit_vertical,
    input  wire logic [15:0]  i_ray_angle,
    input  wire logic [31:0]  i_hit_coord,
    input  wire logic signed [15:0] i_wall_top,
    input  wire logic [15:0]  i_line_length,
    input  wire logic [6:0]   i_width [4],
    input  wire logic [6:0]   i_height [4],
    output logic              o_q_valid,
    output twcr_pkg::t_item   o_q_item,
    input  wire logic         i_q_pop
);
    localparam int SPAN = twcr_pkg::TILE_SIZE * 256;
    localparam int SPW  = $clog2(SPAN) > 0 ? $clog2(SPAN) : 1;
    localparam int HALF = SCREEN_HEIGHT / 2;

    twcr_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    twcr_pkg::t_item n_item;
    logic [1:0] face;
    logic [6:0] w;
    logic [6:0] h;
    logic [SPW-1:0] f;
    logic [SPW+6:0] prod;
    logic [6:0] c;
    logic push;
    logic pop;

    function automatic logic [6:0] clamp_dim(input logic [6:0] v);
        if (v == 7'd0) return 7'd1;
        if (v > 7'd64) return 7'd64;
        return v;
    endfunction

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign pop = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_q[r_rd];

    always_comb begin
        if (!i_hit_vertical) begin
            face = (i_ray_angle > 16'd32768) ? twcr_pkg::FACE_NORTH
                                             : twcr_pkg::FACE_SOUTH;
        end else begin
            face = (i_ray_angle > 16'd16384 && i_ray_angle < 16'd49152)
                 ? twcr_pkg::FACE_WEST : twcr_pkg::FACE_EAST;
        end
        w = clamp_dim(i_width[face]);
        h = clamp_dim(i_height[face]);
        f = SPW'(i_hit_coord % SPAN);
        prod = (SPW+7)'(w) * (SPW+7)'(f);
        c = 7'(prod >> SPW);
        if (c > w - 7'd1) c = w - 7'd1;
        if (face == twcr_pkg::FACE_SOUTH || face == twcr_pkg::FACE_WEST) begin
            c = w - 7'd1 - c;
        end
        n_item = '0;
        n_item.cmd = twcr_pkg::t_cmd'(i_cmd);
        n_item.face = (i_cmd == twcr_pkg::CMD_LOAD) ? i_face : face;
        n_item.addr = {i_face, i_tex_row, i_tex_col};
        n_item.texel = i_texel;
        n_item.column_x = i_column_x;
        n_item.tex_col = c[5:0];
        n_item.height = h;
        n_item.top = 17'(i_wall_top);
        n_item.end_row = 17'(HALF) + 17'(i_line_length >> 1);
        n_item.line_length = i_line_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) r_rd <= ~r_rd;
        end
        if (push) r_q[r_rd ^ r_cnt[0]] <= n_item;
    end
endmodule
`default_nettype wire

@@ rtl/twcr_div.sv @@
// ---------------------------------------------------------------------------
// Step divider
// Restoring divider, one quotient bit per cycle, for ((h-1) << 16) / len.
// ---------------------------------------------------------------------------
`default_nettype none
module twcr_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [22:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_busy,
    output logic [22:0]      o_quo
);
    logic [4:0]  r_cnt;
    logic [22:0] r_num;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] trial;

    assign o_busy = (r_cnt != 5'd0);
    assign o_quo = r_num;
    assign trial = {r_rem, r_num[22]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 5'd23;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            if (!trial[16]) begin
                r_rem <= trial[15:0];
                r_num <= {r_num[21:0], 1'b1};
            end else begin
                r_rem <= {r_rem[14:0], r_num[22]};
                r_num <= {r_num[21:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/twcr_back.sv @@
// ---------------------------------------------------------------------------
// Back part
// Holds the texel memory and the open span, runs the step divide and emits
// one pixel beat per advance item of an open span through an output register.
// ---------------------------------------------------------------------------
`default_nettype none
module twcr_back #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire twcr_pkg::t_item i_q_item,
    output logic             o_q_pop,
    input  wire logic [6:0]  i_height [4],
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_screen_x,
    output logic [9:0]       o_screen_y,
    output logic [31:0]      o_color,
    output logic             o_visible,
    output logic             o_last
);
    logic [31:0] r_mem [16384];
    logic        r_active;
    logic [11:0] r_col_x;
    logic signed [16:0] r_row;
    logic signed [16:0] r_end;
    logic [31:0] r_accum;
    logic [1:0]  r_face;
    logic [5:0]  r_tcol;
    logic        r_pend;
    logic        r_wait_div;
    logic        r_ovalid;
    logic [11:0] r_ox;
    logic [9:0]  r_oy;
    logic        r_ovis;
    logic        r_olast;
    logic        div_busy;
    logic [22:0] div_quo;
    logic [31:0] step;
    logic        div_start;
    logic        is_load;
    logic        is_begin;
    logic        is_adv;
    logic        out_free;
    logic [6:0]  hc;
    logic [15:0] rsel;
    logic [5:0]  rrow;
    logic        vis;
    logic        fin;
    logic [32:0] sum;

    twcr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  ({i_q_item.height - 7'd1, 16'd0}),
        .i_den  (i_q_item.line_length),
        .o_busy (div_busy),
        .o_quo  (div_quo)
    );

    assign step = r_wait_div ? 32'd0 : {9'd0, div_quo};
    assign out_free = !r_ovalid || !i_stall;
    assign is_load  = i_q_item.cmd == twcr_pkg::CMD_LOAD;
    assign is_begin = i_q_item.cmd == twcr_pkg::CMD_BEGIN;
    assign is_adv   = i_q_item.cmd == twcr_pkg::CMD_ADVANCE;

    // An advance in an open span waits for a free output slot and for the step divide.
    always_comb begin
        o_q_pop = 1'b0;
        div_start = 1'b0;
        if (i_q_valid && !div_busy && !r_pend) begin
            if (is_adv) begin
                o_q_pop = !r_active || out_free;
            end else begin
                o_q_pop = 1'b1;
            end
            div_start = is_begin && (i_q_item.line_length != 16'd0);
        end
    end

    always_comb begin
        hc = i_height[r_face];
        if (hc == 7'd0) hc = 7'd1;
        if (hc > 7'd64) hc = 7'd64;
        rsel = r_accum[31:16];
        if (rsel > 16'(hc - 7'd1)) rsel = 16'(hc - 7'd1);
        rrow = rsel[5:0];
        vis = (r_row >= 0) && (r_row < 17'sd0 + 17'(SCREEN_HEIGHT));
        fin = (r_row + 17'sd1) >= r_end;
        sum = {1'b0, r_accum} + {1'b0, step};
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && is_load) r_mem[i_q_item.addr] <= i_q_item.texel;
        if (o_q_pop && is_adv && r_active) o_color <= r_mem[{r_face, rrow, r_tcol}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_pend     <= 1'b0;
            r_wait_div <= 1'b0;
            r_accum    <= '0;
            r_face     <= '0;
        end else begin
            r_pend <= div_start;
            if (r_pend) r_wait_div <= 1'b0;
            if (div_start) r_wait_div <= 1'b1;
            if (o_q_pop && is_adv && r_active) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (o_q_pop && is_begin) begin
                r_face   <= i_q_item.face;
                r_tcol   <= i_q_item.tex_col;
                r_col_x  <= i_q_item.column_x;
                r_row    <= i_q_item.top;
                r_end    <= i_q_item.end_row;
                r_accum  <= '0;
                r_active <= (i_q_item.line_length != 16'd0) &&
                            (i_q_item.top < i_q_item.end_row);
            end else if (o_q_pop && is_adv && r_active) begin
                r_ox     <= r_col_x;
                r_oy     <= vis ? r_row[9:0] : 10'd0;
                r_ovis   <= vis;
                r_olast  <= fin;
                r_row    <= r_row + 17'sd1;
                r_accum  <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (fin) r_active <= 1'b0;
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_screen_x = r_ox;
    assign o_screen_y = r_oy;
    assign o_visible  = r_ovis;
    assign o_last     = r_olast;
endmodule
`default_nettype wire

@@ rtl/textured_wall_column_renderer_top.sv @@
// A pixel beat appears in the cycle after its advance item leaves the queue.
// Throughput: one load or advance item per cycle while the output is free; a begin
// item with nonzero line length holds the back part while the divider makes 23 bits.
// Reset (synchronous, active low) closes any span, empties the queue and
// restores all size registers to 64; the texel memory is not cleared.
// ---------------------------------------------------------------------------
// Textured wall column renderer, top level
// Configuration registers, front classifier and back span engine.
// ---------------------------------------------------------------------------
`default_nettype none
module textured_wall_column_renderer_top #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [1:0]   i_cmd,
    input  wire logic [1:0]   i_face,
    input  wire logic [5:0]   i_tex_row,
    input  wire logic [5:0]   i_tex_col,
    input  wire logic [31:0]  i_texel,
    input  wire logic [11:0]  i_column_x,
    input  wire logic         i_hit_vertical,
    input  wire logic [15:0]  i_ray_angle,
    input  wire logic [31:0]  i_hit_coord,
    input  wire logic signed [15:0] i_wall_top,
    input  wire logic [15:0]  i_line_length,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [6:0]   i_cfg_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [11:0]       o_screen_x,
    output logic [9:0]        o_screen_y,
    output logic [31:0]       o_color,
    output logic              o_visible,
    output logic              o_last
);
    logic [6:0] r_width [4];
    logic [6:0] r_height [4];
    logic q_valid;
    logic q_pop;
    twcr_pkg::t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_width[k]  <= 7'd64;
                r_height[k] <= 7'd64;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index < twcr_pkg::REG_HEIGHT_NORTH) begin
                r_width[i_cfg_index[1:0]] <= i_cfg_data;
            end else begin
                r_height[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    twcr_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd, .i_face, .i_tex_row,
        .i_tex_col, .i_texel, .i_column_x, .i_hit_vertical, .i_ray_angle,
        .i_hit_coord, .i_wall_top, .i_line_length,
        .i_width(r_width), .i_height(r_height),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    twcr_back #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .i_height(r_height), .o_valid, .i_stall, .o_screen_x, .o_screen_y,
        .o_color, .o_visible, .o_last
    );

    a_hidden_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_screen_y == 10'd0)
        else $error("hidden pixel carries a row");
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_color) && $stable(o_screen_y))
        else $error("stalled pixel changed");
endmodule
`default_nettype wire
